### rtl/core/mos_pkg.sv
package mos_pkg;

    // List geometry
    localparam int LIST_DEPTH = 8;
    localparam int KEY_BITS   = 32;

    // Field widths of the channels
    localparam int OPCODE_W    = 2;
    localparam int APP_KEY_W   = 32;
    localparam int READ_IDX_W  = 3;
    localparam int LIST_LEN_W  = 4;
    localparam int READ_KEY_W  = 32;

    // Derived widths
    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W   = COUNT_W + READ_IDX_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MARK  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input beat
        logic compare;  // match all entries, fetch the read entry
        logic update;   // shift the list and load the result register
    } t_dp_cmd;

endpackage

### rtl/core/mos_if.sv
interface mos_in_if;
    import mos_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [APP_KEY_W-1:0]  app_key;
    logic [READ_IDX_W-1:0] read_index;

    modport source (output valid, opcode, app_key, read_index, input ready);
    modport sink   (input valid, opcode, app_key, read_index, output ready);
endinterface

interface mos_out_if;
    import mos_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  status;
    logic [LIST_LEN_W-1:0] list_length;
    logic [READ_KEY_W-1:0] read_key;
    logic                  read_valid;

    modport source (output valid, status, list_length, read_key, read_valid,
                    input ready);
    modport sink   (input valid, status, list_length, read_key, read_valid,
                    output ready);
endinterface

interface mos_cfg_if;
    import mos_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [APP_KEY_W-1:0] excluded_key;

    modport source (output valid, excluded_key, input ready);
    modport sink   (input valid, excluded_key, output ready);
endinterface

### rtl/core/mru_open_stack_core.sv
// Flow: a beat is captured when accepted, matched in the compare step and its result
// loaded in the update step; no new beat is accepted until the update step is done,
// and a stalled result register holds the controller in compare.
// Reset (synchronous, active low): the list is empty and the excluded key is
// zero; stored keys are not cleared and no clearing pass runs.
module mru_open_stack_core
    import mos_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mos_in_if.sink     i_in,
    mos_out_if.source  o_out,
    mos_cfg_if.sink    i_cfg
);

    t_dp_cmd cmd;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    mos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    mos_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_in.opcode),
        .i_app_key     (i_in.app_key),
        .i_read_index  (i_in.read_index),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_data    (i_cfg.excluded_key),
        .o_status      (o_out.status),
        .o_list_length (o_out.list_length),
        .o_read_key    (o_out.read_key),
        .o_read_valid  (o_out.read_valid)
    );

    // The block is busy for the cycle after it accepts a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted back to back");

    // The list never grows past its depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.list_length <= LIST_LEN_W'(LIST_DEPTH)))
        else $error("list length beyond depth");

    // An invalid key never comes with read data
    a_status_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (!o_out.read_valid && o_out.read_key == '0))
        else $error("read data on an invalid argument");

    // A result appears only after a beat went through
    a_result_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> !i_in.ready || $past(!i_in.ready))
        else $error("result without a beat");

endmodule

### rtl/core/mos_ctrl.sv
module mos_ctrl
    import mos_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Result slot is free when empty or draining this cycle
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.update  = (r_state == S_UPD);

    // Sequence one beat through compare and update
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // hold until the result register can take the answer
                if (out_free) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/mos_dp.sv
module mos_dp
    import mos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [APP_KEY_W-1:0]  i_app_key,
    input  logic [READ_IDX_W-1:0] i_read_index,
    input  logic                  i_cfg_we,
    input  logic [APP_KEY_W-1:0]  i_cfg_data,
    output logic                  o_status,
    output logic [LIST_LEN_W-1:0] o_list_length,
    output logic [READ_KEY_W-1:0] o_read_key,
    output logic                  o_read_valid
);

    // Captured command
    t_opcode               r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [READ_IDX_W-1:0] r_idx;
    logic [APP_KEY_W-1:0]  r_excl;

    // List storage
    logic [KEY_BITS-1:0]   r_entries [LIST_DEPTH];
    logic [KEY_BITS-1:0]   n_entries [LIST_DEPTH];
    logic [COUNT_W-1:0]    r_count, n_count;

    // Compare stage results
    logic [LIST_DEPTH-1:0] r_match, n_match;
    logic [KEY_BITS-1:0]   r_rd_key, n_rd_key;

    // Result register
    logic                  r_status, n_status;
    logic [LIST_LEN_W-1:0] r_len;
    logic [READ_KEY_W-1:0] r_rkey, n_rkey;
    logic                  r_rvalid, n_rvalid;

    logic                  hit;
    logic [IDX_W-1:0]      pos;
    logic                  key_zero;
    logic                  key_excluded;
    logic                  idx_in_range;

    // Match every stored entry, fetch the entry under the read index
    always_comb begin
        n_rd_key = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            n_match[i] = (r_entries[i] == r_key) && (COUNT_W'(i) < r_count);
            if (CMP_W'(r_idx) == CMP_W'(i)) begin
                n_rd_key = r_entries[i];
            end
        end
    end

    // First matching position
    always_comb begin
        pos = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                pos = IDX_W'(i);
            end
        end
    end

    assign hit          = |r_match;
    assign key_zero     = (r_key == '0);
    assign key_excluded = (r_excl != '0) && (r_excl == APP_KEY_W'(r_key));
    assign idx_in_range = CMP_W'(r_idx) < CMP_W'(r_count);

    // Next list contents and result
    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_status  = 1'b0;
        n_rkey    = '0;
        n_rvalid  = 1'b0;
        case (r_op)
            OP_MARK: begin
                if (key_zero) begin
                    n_status = 1'b1;
                end else if (!key_excluded) begin
                    // shift down up to the hit, or the whole list on a miss
                    for (int i = 1; i < LIST_DEPTH; i++) begin
                        if (!hit || (IDX_W'(i) <= pos)) begin
                            n_entries[i] = r_entries[i-1];
                        end
                    end
                    n_entries[0] = r_key;
                    if (!hit && (r_count < COUNT_W'(LIST_DEPTH))) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end
            end
            OP_CLOSE: begin
                if (key_zero) begin
                    n_status = 1'b1;
                end else if (hit) begin
                    // close the gap behind the removed entry
                    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                        if (IDX_W'(i) >= pos) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_count = r_count - COUNT_W'(1);
                end
            end
            OP_READ: begin
                if (idx_in_range) begin
                    n_rkey   = READ_KEY_W'(r_rd_key);
                    n_rvalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state: count and excluded key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_excl  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_excl <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_count <= n_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_key <= KEY_BITS'(i_app_key);
            r_idx <= i_read_index;
        end
        if (i_cmd.compare) begin
            r_match  <= n_match;
            r_rd_key <= n_rd_key;
        end
        if (i_cmd.update) begin
            r_entries <= n_entries;
            r_status  <= n_status;
            r_len     <= LIST_LEN_W'(n_count);
            r_rkey    <= n_rkey;
            r_rvalid  <= n_rvalid;
        end
    end

    assign o_status      = r_status;
    assign o_list_length = r_len;
    assign o_read_key    = r_rkey;
    assign o_read_valid  = r_rvalid;

endmodule

### tb/sv/mos_list_checker.sv
`timescale 1ns / 100ps

module mos_list_checker
    import mos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [OPCODE_W-1:0]   i_in_opcode,
    input  logic [APP_KEY_W-1:0]  i_in_app_key,
    input  logic [READ_IDX_W-1:0] i_in_read_index,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_out_status,
    input  logic [LIST_LEN_W-1:0] i_out_list_length,
    input  logic [READ_KEY_W-1:0] i_out_read_key,
    input  logic                  i_out_read_valid,
    // register write channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [APP_KEY_W-1:0]  i_cfg_excluded_key,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                  status;
        logic [LIST_LEN_W-1:0] list_length;
        logic [READ_KEY_W-1:0] read_key;
        logic                  read_valid;
    } t_list_result;

    // Shadow copy of the list and the register
    logic [KEY_BITS-1:0]  mru_keys [LIST_DEPTH];
    logic [COUNT_W-1:0]   mru_count;
    logic [APP_KEY_W-1:0] excluded_key;

    t_list_result pending_results [$];
    int           report_count;

    // Apply one operation to the shadow list and work out its result
    task automatic apply_list_op(input t_opcode op, input logic [KEY_BITS-1:0] key,
                                 input logic [READ_IDX_W-1:0] idx,
                                 output t_list_result res);
        int pos;
        int last;
        int i;
        res = '0;
        pos = -1;
        for (i = 0; i < int'(mru_count); i++) begin
            if (pos < 0 && mru_keys[i] == key) begin
                pos = i;
            end
        end
        case (op)
            OP_MARK: begin
                if (key == '0) begin
                    res.status = 1'b1;
                end else if (!(excluded_key != '0 && key == excluded_key) && pos != 0) begin
                    // absent key: grow the list, or drop the oldest when full; a key further down moves to the front
                    if (pos < 0) begin
                        last = (int'(mru_count) < LIST_DEPTH) ? int'(mru_count) : LIST_DEPTH - 1;
                        if (int'(mru_count) < LIST_DEPTH) begin
                            mru_count = mru_count + 1'b1;
                        end
                    end else begin
                        last = pos;
                    end
                    for (i = last; i > 0; i--) begin
                        mru_keys[i] = mru_keys[i-1];
                    end
                    mru_keys[0] = key;
                end
            end
            OP_CLOSE: begin
                if (key == '0) begin
                    res.status = 1'b1;
                end else if (pos >= 0) begin
                    // close the gap behind the removed key
                    for (i = pos + 1; i < int'(mru_count); i++) begin
                        mru_keys[i-1] = mru_keys[i];
                    end
                    mru_count = mru_count - 1'b1;
                end
            end
            OP_READ: begin
                if (int'(idx) < int'(mru_count)) begin
                    res.read_key   = mru_keys[idx];
                    res.read_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.list_length = mru_count;
    endtask

    // Watch the channels at each rising edge
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            mru_count    = '0;
            excluded_key = '0;
            pending_results.delete();
            report_count = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // compare a result beat with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_status, i_out_list_length, i_out_read_key, i_out_read_valid};
                if (pending_results.size() == 0) begin
                    if (report_count < MAX_REPORTS) begin
                        $display("%0t: result beat with nothing expected: status %0d length %0d key %h valid %0d",
                                 $time, got.status, got.list_length, got.read_key,
                                 got.read_valid);
                    end
                    report_count = report_count + 1;
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (report_count < MAX_REPORTS) begin
                            $display("%0t: mismatch exp/got: status %0d/%0d length %0d/%0d key %h/%h valid %0d/%0d",
                                     $time, want.status, got.status, want.list_length,
                                     got.list_length, want.read_key, got.read_key,
                                     want.read_valid, got.read_valid);
                        end
                        report_count = report_count + 1;
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // predict the result of an input beat
            if (i_in_valid && i_in_ready) begin
                apply_list_op(t_opcode'(i_in_opcode), i_in_app_key, i_in_read_index, want);
                pending_results.push_back(want);
            end
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                excluded_key = i_cfg_excluded_key;
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

### tb/sv/mru_open_stack_core_tb.sv
`timescale 1ns / 100ps

module mru_open_stack_core_tb;
    import mos_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASES       = 5;
    localparam int POOL_SIZE    = 12;

    logic clk = 1'b0;
    logic rst_n;

    mos_in_if  in_ch ();
    mos_out_if out_ch ();
    mos_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int ready_stall = 0;
    bit steady = 1'b0;
    bit in_raised = 1'b0;

    logic [APP_KEY_W-1:0] key_pool [POOL_SIZE];
    logic [APP_KEY_W-1:0] excl_now;

    always #2 clk = ~clk;

    mru_open_stack_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mos_list_checker list_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_ch.valid),
        .i_in_ready         (in_ch.ready),
        .i_in_opcode        (in_ch.opcode),
        .i_in_app_key       (in_ch.app_key),
        .i_in_read_index    (in_ch.read_index),
        .i_out_valid        (out_ch.valid),
        .i_out_ready        (out_ch.ready),
        .i_out_status       (out_ch.status),
        .i_out_list_length  (out_ch.list_length),
        .i_out_read_key     (out_ch.read_key),
        .i_out_read_valid   (out_ch.read_valid),
        .i_cfg_valid        (cfg_ch.valid),
        .i_cfg_ready        (cfg_ch.ready),
        .i_cfg_excluded_key (cfg_ch.excluded_key),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Stall the result channel at random, except in steady stretches
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            ready_stall  <= 0;
        end else if (steady) begin
            out_ch.ready <= 1'b1;
        end else if (ready_stall != 0) begin
            out_ch.ready <= 1'b0;
            ready_stall  <= ready_stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                ready_stall <= pick_gap();
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one beat, hold it until accepted, then maybe idle
    task automatic send_op(input t_opcode op, input logic [APP_KEY_W-1:0] key,
                           input logic [READ_IDX_W-1:0] idx);
        int gap;
        in_ch.opcode     <= op;
        in_ch.app_key    <= key;
        in_ch.read_index <= idx;
        in_ch.valid      <= 1'b1;
        in_raised = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            in_raised = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_list_idle();
        if (in_raised) begin
            in_ch.valid <= 1'b0;
            in_raised = 1'b0;
        end
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_excluded(input logic [APP_KEY_W-1:0] key);
        cfg_ch.excluded_key <= key;
        cfg_ch.valid        <= 1'b1;
        excl_now = key;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random operations over a small key pool so that hits and evictions are common
    task automatic run_list_traffic(input int count);
        int r;
        int n;
        t_opcode op;
        logic [APP_KEY_W-1:0] key;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                steady <= ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                op = OP_MARK;
            end else if (r < 65) begin
                op = OP_CLOSE;
            end else if (r < 95) begin
                op = OP_READ;
            end else begin
                op = OP_NOP;
            end
            r = $urandom_range(0, 99);
            if (r < 75) begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (r < 85) begin
                key = $urandom;
            end else if (r < 92) begin
                key = '0;
            end else begin
                key = excl_now;
            end
            send_op(op, key, READ_IDX_W'($urandom_range(0, 7)));
        end
        steady <= 1'b0;
    endtask

    initial begin
        int p;
        int i;
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= OP_NOP;
        in_ch.app_key       <= '0;
        in_ch.read_index    <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.excluded_key <= '0;
        excl_now = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, invalid and excluded keys, overflow, move, close
        write_excluded(32'hFFFF_FFFF);
        send_op(OP_READ,  32'h0, 3'd0);
        send_op(OP_CLOSE, 32'h7, 3'd0);
        send_op(OP_MARK,  32'h0, 3'd0);
        send_op(OP_CLOSE, 32'h0, 3'd0);
        send_op(OP_MARK,  32'hFFFF_FFFF, 3'd0);
        send_op(OP_MARK,  32'h0000_0001, 3'd0);
        send_op(OP_MARK,  32'h8000_0000, 3'd0);
        send_op(OP_MARK,  32'hFFFF_FFFE, 3'd0);
        send_op(OP_MARK,  32'h5555_5555, 3'd0);
        send_op(OP_MARK,  32'hAAAA_AAAA, 3'd0);
        send_op(OP_MARK,  32'h0000_0003, 3'd0);
        send_op(OP_MARK,  32'h0000_0004, 3'd0);
        send_op(OP_MARK,  32'h0000_0005, 3'd7);
        send_op(OP_MARK,  32'h0000_0006, 3'd0);
        send_op(OP_MARK,  32'h0000_0006, 3'd0);
        send_op(OP_MARK,  32'h5555_5555, 3'd0);
        send_op(OP_READ,  32'h0, 3'd7);
        send_op(OP_READ,  32'hDEAD_BEEF, 3'd0);
        send_op(OP_CLOSE, 32'h0000_0003, 3'd0);
        send_op(OP_CLOSE, 32'h0000_0001, 3'd0);
        send_op(OP_READ,  32'h0, 3'd7);
        send_op(OP_READ,  32'h0, 3'd6);
        send_op(OP_NOP,   32'h1234_5678, 3'd5);
        wait_list_idle();

        // Random phases, each under its own excluded key
        for (p = 0; p < PHASES; p++) begin
            key_pool[0] = 32'h0000_0001;
            key_pool[1] = 32'h0000_0002;
            key_pool[2] = 32'hFFFF_FFFF;
            for (i = 3; i < POOL_SIZE; i++) begin
                key_pool[i] = $urandom;
                if (key_pool[i] == '0) begin
                    key_pool[i] = 32'h0000_0100;
                end
            end
            case (p)
                0: write_excluded(32'h0);
                1: write_excluded(key_pool[4]);
                2: write_excluded(32'h0000_0001);
                3: write_excluded($urandom);
                default: write_excluded(32'hFFFF_FFFF);
            endcase
            run_list_traffic(PHASE_ITEMS);
            wait_list_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/mos_pkg.sv
rtl/core/mos_if.sv
rtl/core/mos_ctrl.sv
rtl/core/mos_dp.sv
rtl/core/mru_open_stack_core.sv
tb/sv/mos_list_checker.sv
tb/sv/mru_open_stack_core_tb.sv
